### rtl/core/sgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

	localparam int ESC_LIMIT_DEF = 16;

	localparam int COLOR_W   = 3;
	localparam int CHAR_W    = 8;
	localparam int FIELD_W   = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0] CH_ESC     = 8'd27;
	localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
	localparam logic [CHAR_W-1:0] CH_M       = 8'h6D;
	localparam logic [CHAR_W-1:0] CH_BRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

	localparam logic [FIELD_W-1:0] FIELD_MAX = 7'd99;
	localparam logic [FIELD_W-1:0] CODE_RESET     = 7'd0;
	localparam logic [FIELD_W-1:0] CODE_BOLD      = 7'd1;
	localparam logic [FIELD_W-1:0] CODE_UNDERLINE = 7'd4;
	localparam logic [FIELD_W-1:0] CODE_FORE_LO   = 7'd30;
	localparam logic [FIELD_W-1:0] CODE_FORE_HI   = 7'd37;
	localparam logic [FIELD_W-1:0] CODE_BACK_LO   = 7'd40;
	localparam logic [FIELD_W-1:0] CODE_BACK_HI   = 7'd47;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FORE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BACK = 1'd1;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_BS   = 1'b1;

	typedef struct packed {
		logic               underline;
		logic               bold;
		logic [COLOR_W-1:0] back;
		logic [COLOR_W-1:0] fore;
	} attr_t;

	typedef struct packed {
		logic [FIELD_W-1:0] value;
		logic               stopped;
		attr_t              pending;
		attr_t              applied;
	} field_upd_t;

endpackage

`default_nettype wire

### rtl/core/ansi_sgr_text_attribute_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses a byte stream carrying ANSI SGR escape sequences and emits each byte outside a
// sequence with its color, bold and underline attributes, and each backspace as a result
// of its own. An ordinary byte is taken while the block is idle and its result is held in
// an output register, so bytes flow at one per cycle while the output side keeps up and
// no abort is being replayed. Characters of an open escape sequence are kept in a small
// RAM; when a sequence is aborted, each stored character is replayed by a RAM read and
// then a transfer into the output register, followed by the aborting byte. When the
// aborting byte is itself an escape, it opens the next sequence without a result of its
// own. The default colors written through the configuration port take effect at the
// next reset code in the stream.
module ansi_sgr_text_attribute_parser
	import sgr_pkg::*;
#(
	parameter int ESC_LIMIT = ESC_LIMIT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CHAR_W-1:0]    char_code,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      kind,
	output logic [CHAR_W-1:0]         out_char,
	output logic [COLOR_W-1:0]        fore_index,
	output logic [COLOR_W-1:0]        back_index,
	output logic                      bold_on,
	output logic                      underline_on,
	output logic                      last,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data
);

	localparam int IW = $clog2(ESC_LIMIT);
	localparam int CW = $clog2(ESC_LIMIT + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;
	localparam logic [1:0] ST_TAIL = 2'd3;

	logic [1:0]         state_q;
	logic               in_escape_q;
	logic               bracket_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic [FIELD_W-1:0] field_value_q;
	logic               field_stopped_q;
	attr_t              pending_q;
	attr_t              current_q;
	logic [COLOR_W-1:0] default_fore_q;
	logic [COLOR_W-1:0] default_back_q;
	logic [CHAR_W-1:0]  pend_char_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [CHAR_W-1:0]  out_char_q;
	attr_t              out_attr_q;
	logic               last_q;

	logic               out_free;
	logic               accept;
	logic               is_collect;
	logic               is_abort;
	logic               do_store;
	logic               replay_last;
	logic               ram_we;
	logic               ram_re;
	logic [CHAR_W-1:0]  ram_rdata;
	field_upd_t         upd;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) && out_free;
	assign accept     = in_valid && in_ready;
	assign is_collect = char_code inside {[CH_ZERO:CH_NINE]} || char_code == CH_SEMI
		|| char_code == CH_BRACKET;
	assign is_abort   = in_escape_q && char_code != CH_M && !is_collect;
	assign do_store   = count_q < CW'(ESC_LIMIT);
	assign ram_we     = accept && in_escape_q && is_collect && do_store;
	assign ram_re     = (state_q == ST_READ);
	assign replay_last = (CW'(idx_q) == count_q - CW'(1));

	sgr_field u_field (
		.char_code    (char_code),
		.field_value  (field_value_q),
		.field_stopped(field_stopped_q),
		.pending      (pending_q),
		.default_fore (default_fore_q),
		.default_back (default_back_q),
		.upd          (upd)
	);

	sgr_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(ESC_LIMIT)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IW-1:0]),
		.wdata(char_code),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fore_q <= 3'd0;
			default_back_q <= 3'd7;
		end else if (cfg_we) begin
			if (cfg_index == REG_DEFAULT_FORE) begin
				default_fore_q <= cfg_data;
			end else if (cfg_index == REG_DEFAULT_BACK) begin
				default_back_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			in_escape_q     <= 1'b0;
			bracket_q       <= 1'b0;
			count_q         <= '0;
			idx_q           <= '0;
			field_value_q   <= '0;
			field_stopped_q <= 1'b0;
			pending_q       <= '{underline: 1'b0, bold: 1'b0, back: 3'd7, fore: 3'd0};
			current_q       <= '{underline: 1'b0, bold: 1'b0, back: 3'd7, fore: 3'd0};
			out_valid_q     <= 1'b0;
			pend_char_q     <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_escape_q && char_code == CH_M) begin
							if (bracket_q) begin
								current_q <= upd.applied;
								pending_q <= upd.applied;
							end
							in_escape_q <= 1'b0;
						end else if (in_escape_q && is_collect) begin
							if (do_store) begin
								if (bracket_q) begin
									field_value_q   <= upd.value;
									field_stopped_q <= upd.stopped;
									pending_q       <= upd.pending;
								end
								if (count_q == '0 && char_code == CH_BRACKET) begin
									bracket_q <= 1'b1;
								end
								count_q <= count_q + CW'(1);
							end
						end else if (is_abort && count_q != '0) begin
							in_escape_q <= 1'b0;
							pend_char_q <= char_code;
							idx_q       <= '0;
							state_q     <= ST_READ;
						end else begin
							in_escape_q <= 1'b0;
							if (char_code == CH_ESC) begin
								in_escape_q     <= 1'b1;
								bracket_q       <= 1'b0;
								count_q         <= '0;
								field_value_q   <= '0;
								field_stopped_q <= 1'b0;
								pending_q       <= current_q;
							end else begin
								out_valid_q <= 1'b1;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (replay_last) begin
							if (pend_char_q == CH_ESC) begin
								in_escape_q     <= 1'b1;
								bracket_q       <= 1'b0;
								count_q         <= '0;
								field_value_q   <= '0;
								field_stopped_q <= 1'b0;
								pending_q       <= current_q;
								state_q         <= ST_IDLE;
							end else begin
								state_q <= ST_TAIL;
							end
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_TAIL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload; loaded on the same conditions that set the output valid.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && !(in_escape_q && !is_abort)
			&& !(is_abort && count_q != '0) && char_code != CH_ESC) begin
			if (char_code == CH_BS) begin
				kind_q     <= KIND_BS;
				out_char_q <= CH_BS;
				out_attr_q <= '0;
			end else begin
				kind_q     <= KIND_CHAR;
				out_char_q <= char_code;
				out_attr_q <= current_q;
			end
			last_q <= 1'b1;
		end else if (state_q == ST_SEND && out_free) begin
			kind_q     <= KIND_CHAR;
			out_char_q <= ram_rdata;
			out_attr_q <= current_q;
			last_q     <= replay_last && pend_char_q == CH_ESC;
		end else if (state_q == ST_TAIL && out_free) begin
			if (pend_char_q == CH_BS) begin
				kind_q     <= KIND_BS;
				out_char_q <= CH_BS;
				out_attr_q <= '0;
			end else begin
				kind_q     <= KIND_CHAR;
				out_char_q <= pend_char_q;
				out_attr_q <= current_q;
			end
			last_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign out_char     = out_char_q;
	assign fore_index   = out_attr_q.fore;
	assign back_index   = out_attr_q.back;
	assign bold_on      = out_attr_q.bold;
	assign underline_on = out_attr_q.underline;
	assign last         = last_q;

endmodule

`default_nettype wire

### rtl/core/sgr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/sgr_field.sv
`timescale 1ns / 1ps
`default_nettype none

module sgr_field
	import sgr_pkg::*;
(
	input  wire logic [CHAR_W-1:0]  char_code,
	input  wire logic [FIELD_W-1:0] field_value,
	input  wire logic               field_stopped,
	input  wire attr_t              pending,
	input  wire logic [COLOR_W-1:0] default_fore,
	input  wire logic [COLOR_W-1:0] default_back,
	output field_upd_t              upd
);

	attr_t        applied;
	logic [9:0]   acc;
	logic [FIELD_W-1:0] diff;

	always_comb begin
		applied = pending;
		diff    = '0;
		if (field_value == CODE_RESET) begin
			applied = '{underline: 1'b0, bold: 1'b0, back: default_back, fore: default_fore};
		end else if (field_value == CODE_BOLD) begin
			applied.bold = 1'b1;
		end else if (field_value == CODE_UNDERLINE) begin
			applied.underline = 1'b1;
		end else if (field_value inside {[CODE_FORE_LO:CODE_FORE_HI]}) begin
			diff = field_value - CODE_FORE_LO;
			applied.fore = diff[COLOR_W-1:0];
		end else if (field_value inside {[CODE_BACK_LO:CODE_BACK_HI]}) begin
			diff = field_value - CODE_BACK_LO;
			applied.back = diff[COLOR_W-1:0];
		end
	end

	assign acc = 10'(field_value) * 10'd10 + 10'(char_code - CH_ZERO);

	always_comb begin
		upd.applied = applied;
		upd.value   = field_value;
		upd.stopped = field_stopped;
		upd.pending = pending;
		if (char_code == CH_SEMI) begin
			upd.pending = applied;
			upd.value   = '0;
			upd.stopped = 1'b0;
		end else if (char_code inside {[CH_ZERO:CH_NINE]} && !field_stopped) begin
			upd.value = (acc > 10'(FIELD_MAX)) ? FIELD_MAX : acc[FIELD_W-1:0];
		end else begin
			upd.stopped = 1'b1;
		end
	end

endmodule

`default_nettype wire

### bench/tb_ansi_sgr_text_attribute_parser.sv
`timescale 1ns / 1ps

module tb_ansi_sgr_text_attribute_parser;
	import sgr_pkg::*;

	localparam int ESC_DEPTH = ESC_LIMIT_DEF;
	localparam int RANDOM_BYTES = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] ch;
		attr_t             attr;
		logic              last;
	} glyph_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    char_code;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 kind;
	logic [CHAR_W-1:0]    out_char;
	logic [COLOR_W-1:0]   fore_index;
	logic [COLOR_W-1:0]   back_index;
	logic                 bold_on;
	logic                 underline_on;
	logic                 last;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	logic              in_esc = 1'b0;
	logic [CHAR_W-1:0] esc_buf [ESC_DEPTH];
	int                esc_len = 0;
	int                fld_val = 0;
	logic              fld_stop = 1'b0;
	attr_t             pend_attrs = {1'b0, 1'b0, 3'd7, 3'd0};
	attr_t             cur_attrs = {1'b0, 1'b0, 3'd7, 3'd0};
	logic [COLOR_W-1:0] dflt_fore = 3'd0;
	logic [COLOR_W-1:0] dflt_back = 3'd7;

	glyph_t expected_glyphs [$];
	int     error_count = 0;
	int     bytes_sent = 0;
	int     burst_left = 0;
	int     cycle_count = 0;
	int     hold_tickets = 0;
	int     hold_served = 0;
	int     hold_left = 0;

	ansi_sgr_text_attribute_parser #(
		.ESC_LIMIT(ESC_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_char(out_char),
		.fore_index(fore_index),
		.back_index(back_index),
		.bold_on(bold_on),
		.underline_on(underline_on),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic is_collected(logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI || c == CH_BRACKET;
	endfunction

	function automatic attr_t apply_sgr(attr_t a, int v);
		attr_t r;
		r = a;
		if (v == CODE_RESET) begin
			r = '0;
			r.fore = dflt_fore;
			r.back = dflt_back;
		end else if (v == CODE_BOLD) begin
			r.bold = 1'b1;
		end else if (v == CODE_UNDERLINE) begin
			r.underline = 1'b1;
		end else if (v >= CODE_FORE_LO && v <= CODE_FORE_HI) begin
			r.fore = COLOR_W'(v - CODE_FORE_LO);
		end else if (v >= CODE_BACK_LO && v <= CODE_BACK_HI) begin
			r.back = COLOR_W'(v - CODE_BACK_LO);
		end
		return r;
	endfunction

	// Updates the parser state for one byte and queues the characters it releases.
	function automatic void decode_byte(logic [CHAR_W-1:0] c);
		glyph_t run [$];
		glyph_t g;
		if (in_esc) begin
			if (c == CH_M) begin
				if (esc_len > 0 && esc_buf[0] == CH_BRACKET) begin
					pend_attrs = apply_sgr(pend_attrs, fld_val);
					cur_attrs = pend_attrs;
				end
				in_esc = 1'b0;
				return;
			end
			if (is_collected(c)) begin
				if (esc_len < ESC_DEPTH) begin
					if (esc_len >= 1 && esc_buf[0] == CH_BRACKET) begin
						if (c == CH_SEMI) begin
							pend_attrs = apply_sgr(pend_attrs, fld_val);
							fld_val = 0;
							fld_stop = 1'b0;
						end else if (c >= CH_ZERO && c <= CH_NINE && !fld_stop) begin
							fld_val = fld_val * 10 + int'(c - CH_ZERO);
							if (fld_val > int'(FIELD_MAX))
								fld_val = int'(FIELD_MAX);
						end else begin
							fld_stop = 1'b1;
						end
					end
					esc_buf[esc_len] = c;
					esc_len++;
				end
				return;
			end
			in_esc = 1'b0;
			for (int i = 0; i < esc_len; i++) begin
				g.kind = KIND_CHAR;
				g.ch = esc_buf[i];
				g.attr = cur_attrs;
				g.last = 1'b0;
				run.push_back(g);
			end
		end
		if (c == CH_ESC) begin
			in_esc = 1'b1;
			esc_len = 0;
			fld_val = 0;
			fld_stop = 1'b0;
			pend_attrs = cur_attrs;
		end else begin
			g.kind = (c == CH_BS) ? KIND_BS : KIND_CHAR;
			g.ch = c;
			g.attr = (c == CH_BS) ? attr_t'('0) : cur_attrs;
			g.last = 1'b0;
			run.push_back(g);
		end
		for (int i = 0; i < run.size(); i++) begin
			g = run[i];
			g.last = (i == run.size() - 1);
			expected_glyphs.push_back(g);
		end
	endfunction

	task automatic compare_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_glyphs.size() == 0) begin
				error_count++;
				$display("%0t: unexpected transfer, expected none, got char %0h kind %0b",
					$time, out_char, kind);
			end else begin
				want = expected_glyphs.pop_front();
				compare_field("kind", 8'(want.kind), 8'(kind));
				compare_field("out_char", want.ch, out_char);
				compare_field("fore_index", 8'(want.attr.fore), 8'(fore_index));
				compare_field("back_index", 8'(want.attr.back), 8'(back_index));
				compare_field("bold_on", 8'(want.attr.bold), 8'(bold_on));
				compare_field("underline_on", 8'(want.attr.underline), 8'(underline_on));
				compare_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// The receiver follows a rotating pattern and honors requests for a long hold.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_tickets) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			case ((cycle_count / 97) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	task automatic send_byte(input logic [CHAR_W-1:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_byte(c);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_sgr(input string body);
		send_byte(CH_ESC);
		send_text(body);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_glyphs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_defaults(input logic [COLOR_W-1:0] fore, input logic [COLOR_W-1:0] back);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEFAULT_FORE;
		cfg_data <= fore;
		@(posedge clk);
		cfg_index <= REG_DEFAULT_BACK;
		cfg_data <= back;
		@(posedge clk);
		cfg_we <= 1'b0;
		dflt_fore = fore;
		dflt_back = back;
	endtask

	function automatic logic [CHAR_W-1:0] random_collected();
		case ($urandom_range(0, 11))
			10: return CH_SEMI;
			11: return CH_BRACKET;
			default: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] sequence_end();
		logic [CHAR_W-1:0] c;
		case ($urandom_range(0, 7))
			0: return CH_ESC;
			1: return CH_BS;
			2: begin
				c = CHAR_W'($urandom_range(1, 255));
				while (is_collected(c) || c == CH_M)
					c = CHAR_W'($urandom_range(1, 255));
				return c;
			end
			default: return CH_M;
		endcase
	endfunction

	task automatic test_plain_bytes();
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(CH_BS);
		send_byte(8'h80);
	endtask

	task automatic test_sgr_codes();
		send_sgr("[1;4;37;40m");
		send_text("A");
		send_sgr("[31;47;99;5m");
		send_text("b");
		send_sgr("m");
		send_sgr("[m");
		send_text("c");
	endtask

	task automatic test_aborts_and_limit();
		send_sgr("[123[5");
		send_sgr(";2");
		send_byte(CH_BS);
		send_sgr("[4444;32m");
		send_sgr("1;2m");
		send_sgr("9999999999;;;;;;;;;;z");
	endtask

	task automatic test_default_colors();
		wait_idle();
		set_defaults(3'd7, 3'd0);
		send_sgr("[0m");
		send_text("x");
		wait_idle();
		set_defaults(3'd0, 3'd7);
		send_sgr("[1;m");
		send_text("y");
		wait_idle();
		set_defaults(COLOR_W'($urandom_range(0, 7)), COLOR_W'($urandom_range(0, 7)));
		send_sgr("[;4m");
		send_text("z");
	endtask

	// The output side holds off while a long aborted sequence and text keep coming.
	task automatic test_output_stall();
		wait_idle();
		hold_tickets <= hold_tickets + 1;
		send_byte(CH_ESC);
		repeat (18) send_byte(random_collected());
		send_byte(CH_BS);
		repeat (30) send_byte(CHAR_W'($urandom_range(32, 126)));
		wait_idle();
	endtask

	task automatic test_random_stream();
		int start;
		int next_cfg;
		int fields;
		int code;
		int len;
		start = bytes_sent;
		next_cfg = bytes_sent + 65;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (bytes_sent >= next_cfg) begin
				wait_idle();
				set_defaults(COLOR_W'($urandom_range(0, 7)), COLOR_W'($urandom_range(0, 7)));
				next_cfg = bytes_sent + 65;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send_byte(CH_ESC);
					if ($urandom_range(0, 9) != 0)
						send_byte(CH_BRACKET);
					fields = $urandom_range(1, 4);
					for (int f = 0; f < fields; f++) begin
						if (f > 0)
							send_byte(CH_SEMI);
						case ($urandom_range(0, 7))
							0: code = -1;
							1: code = 0;
							2: code = $urandom_range(0, 1) ? 1 : 4;
							3, 4: code = 30 + $urandom_range(0, 7);
							5, 6: code = 40 + $urandom_range(0, 7);
							default: code = $urandom_range(0, 999);
						endcase
						if (code >= 0) begin
							if ($urandom_range(0, 7) == 0)
								send_byte(CH_ZERO);
							send_text($sformatf("%0d", code));
						end
						if ($urandom_range(0, 11) == 0)
							send_text("[7");
					end
					send_byte(sequence_end());
				end
				4, 5: begin
					send_byte(CH_ESC);
					len = $urandom_range(0, 22);
					repeat (len) send_byte(random_collected());
					send_byte(sequence_end());
				end
				default: begin
					len = $urandom_range(1, 6);
					repeat (len) begin
						if ($urandom_range(0, 7) == 0)
							send_byte(CH_BS);
						else
							send_byte(CHAR_W'($urandom_range(1, 255)));
					end
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		cfg_we = 1'b0;
		cfg_index = REG_DEFAULT_FORE;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_sgr_codes();
		test_aborts_and_limit();
		test_default_colors();
		test_output_stall();
		test_random_stream();
		wait_idle();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
rtl/core/sgr_pkg.sv
rtl/core/sgr_ram.sv
rtl/core/sgr_field.sv
rtl/core/ansi_sgr_text_attribute_parser.sv
bench/tb_ansi_sgr_text_attribute_parser.sv
